### rtl/fbb_pkg.sv
// shared constants, codes and types of the free block bitmap
`default_nettype none
package fbb_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int BLOCK_BITS = 8;
   localparam int MAP_BYTES = NUM_BLOCKS / BLOCK_BITS;
   localparam int ADDR_W = $clog2(MAP_BYTES);
   localparam int BIT_W = $clog2(BLOCK_BITS);
   localparam int POS_W = ADDR_W + BIT_W;
   localparam int CSR_W = 8;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_MARK_USED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK_FREE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEST = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(MAP_BYTES);

   typedef struct packed {
      logic [BLOCK_BITS-1:0] new_byte;
      logic                  bit_value;
      logic                  has_free;
      logic [BIT_W-1:0]      free_bit;
   } byte_result_type;

endpackage
`default_nettype wire

### rtl/fbb_byte_unit.sv
// shared byte unit: bit update, bit test and lowest free bit search
`default_nettype none
module fbb_byte_unit (
   input  wire logic [fbb_pkg::BLOCK_BITS-1:0] byte_in,
   input  wire logic [fbb_pkg::KIND_W-1:0]     kind,
   input  wire logic [fbb_pkg::BIT_W-1:0]      bit_sel,
   output fbb_pkg::byte_result_type            result
);

   logic [fbb_pkg::BLOCK_BITS-1:0] mask;

   always_comb begin
      mask = '0;
      mask[bit_sel] = 1'b1;
      result = '0;
      result.bit_value = byte_in[bit_sel];
      case (kind)
         fbb_pkg::KIND_MARK_USED: result.new_byte = byte_in | mask;
         fbb_pkg::KIND_MARK_FREE: result.new_byte = byte_in & ~mask;
         default:                 result.new_byte = byte_in;
      endcase
      for (int i = fbb_pkg::BLOCK_BITS - 1; i >= 0; i--) begin
         if (!byte_in[i]) begin
            result.has_free = 1'b1;
            result.free_bit = fbb_pkg::BIT_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

### rtl/free_block_bitmap.sv
// top level of the free block bitmap allocator
// A mark or test transaction runs from acceptance to the result register in order:
// the accept cycle starts the memory read, the byte state updates or tests through
// the byte unit, and the result state loads the result. A search reads one map
// byte per cycle, through the registered read of the map memory, from byte 0
// upward and stops at the first byte with a zero bit; the bytes scanned number at
// most bytes_in_use, capped at 128. Out-of-range positions and a search with no
// bytes in use go straight from acceptance to the result state. One transaction
// is in flight at a time; a finished result may wait in the output register while
// the next transaction is accepted and processed. The map needs no clearing pass:
// per-byte valid bits make unwritten bytes read as free, with block 0 used.
`default_nettype none
module free_block_bitmap (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [fbb_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [fbb_pkg::POS_W-1:0]     req_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_bit_value,
   output logic [fbb_pkg::POS_W-1:0]          rsp_free_index,
   output logic [fbb_pkg::STATUS_W-1:0]       rsp_status,
   input  wire logic                          csr_wr_en,
   input  wire logic [fbb_pkg::CSR_W-1:0]     csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_BYTE,
      S_SCAN,
      S_RES
   } state_type;

   state_type state_ff, state_in;

   logic [fbb_pkg::CSR_W-1:0]      bytes_ff;
   logic [fbb_pkg::CSR_W-1:0]      limit_ff, limit_in, limit_now;
   logic [fbb_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [fbb_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [fbb_pkg::ADDR_W-1:0]     scan_ff, scan_in;
   logic [fbb_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic                           res_bit_ff, res_bit_in;
   logic [fbb_pkg::POS_W-1:0]      res_idx_ff, res_idx_in;
   logic [fbb_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_bit_ff;
   logic [fbb_pkg::POS_W-1:0]      rsp_idx_ff;
   logic [fbb_pkg::STATUS_W-1:0]   rsp_status_ff;

   logic [fbb_pkg::BLOCK_BITS-1:0] map_mem [fbb_pkg::MAP_BYTES];
   logic [fbb_pkg::MAP_BYTES-1:0]  entry_vld_ff;
   logic [fbb_pkg::BLOCK_BITS-1:0] mem_q_ff;
   logic                           vld_q_ff;
   logic                           first_q_ff;
   logic [fbb_pkg::ADDR_W-1:0]     rd_addr;
   logic                           mem_we;
   logic [fbb_pkg::BLOCK_BITS-1:0] cur_byte;
   logic                           req_take;
   logic                           out_free;
   logic                           in_range;
   logic                           last_byte;

   fbb_pkg::byte_result_type       unit_res;

   fbb_byte_unit u_byte_unit (
      .byte_in (cur_byte),
      .kind    (kind_ff),
      .bit_sel (bit_ff),
      .result  (unit_res)
   );

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign limit_now = (bytes_ff > fbb_pkg::CSR_RESET) ? fbb_pkg::CSR_RESET : bytes_ff;
   assign in_range  = {1'b0, req_position} < {limit_now, 3'b000};
   assign cur_byte  = vld_q_ff ? mem_q_ff
                               : {{(fbb_pkg::BLOCK_BITS-1){1'b0}}, first_q_ff};
   assign last_byte = ({1'b0, addr_ff} + 8'd1) == limit_ff;
   assign mem_we    = (state_ff == S_BYTE) &&
                      ((kind_ff == fbb_pkg::KIND_MARK_USED) ||
                       (kind_ff == fbb_pkg::KIND_MARK_FREE));
   assign rd_addr   = (state_ff == S_SCAN) ? scan_ff
                    : (req_kind == fbb_pkg::KIND_SEARCH) ? '0
                    : req_position[fbb_pkg::POS_W-1:fbb_pkg::BIT_W];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      scan_in       = scan_ff;
      bit_in        = bit_ff;
      res_bit_in    = res_bit_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_in       = req_kind;
               limit_in      = limit_now;
               addr_in       = req_position[fbb_pkg::POS_W-1:fbb_pkg::BIT_W];
               bit_in        = req_position[fbb_pkg::BIT_W-1:0];
               res_bit_in    = 1'b0;
               res_idx_in    = '0;
               res_status_in = fbb_pkg::STATUS_OK;
               if (req_kind == fbb_pkg::KIND_SEARCH) begin
                  addr_in = '0;
                  scan_in = fbb_pkg::ADDR_W'(1);
                  if (limit_now == '0) begin
                     res_status_in = fbb_pkg::STATUS_NO_FREE;
                     state_in      = S_RES;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (!in_range) begin
                  res_status_in = fbb_pkg::STATUS_RANGE;
                  state_in      = S_RES;
               end else begin
                  state_in = S_BYTE;
               end
            end
         end
         S_BYTE: begin
            if (kind_ff == fbb_pkg::KIND_TEST) begin
               res_bit_in = unit_res.bit_value;
            end
            state_in = S_RES;
         end
         S_SCAN: begin
            if (unit_res.has_free) begin
               res_idx_in = {addr_ff, unit_res.free_bit};
               state_in   = S_RES;
            end else if (last_byte) begin
               res_status_in = fbb_pkg::STATUS_NO_FREE;
               state_in      = S_RES;
            end else begin
               addr_in = addr_ff + fbb_pkg::ADDR_W'(1);
               scan_in = scan_ff + fbb_pkg::ADDR_W'(1);
            end
         end
         S_RES: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = ((state_ff == S_RES) && out_free) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         bytes_ff     <= fbb_pkg::CSR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bytes_ff <= csr_wr_data;
         end
      end
      limit_ff      <= limit_in;
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      scan_ff       <= scan_in;
      bit_ff        <= bit_in;
      res_bit_ff    <= res_bit_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      if ((state_ff == S_RES) && out_free) begin
         rsp_bit_ff    <= res_bit_ff;
         rsp_idx_ff    <= res_idx_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // map memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[addr_ff] <= unit_res.new_byte;
      end
      mem_q_ff   <= map_mem[rd_addr];
      vld_q_ff   <= entry_vld_ff[rd_addr];
      first_q_ff <= (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (mem_we) begin
         entry_vld_ff[addr_ff] <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bit_value  = rsp_bit_ff;
   assign rsp_free_index = rsp_idx_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("accepted transaction left sequencer idle");

   a_rsp_from_res: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RES))
      else $error("response raised outside result state");

   a_no_test_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BYTE) && (kind_ff == fbb_pkg::KIND_TEST) |-> !mem_we)
      else $error("test transaction wrote the map");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> ({1'b0, addr_ff} < limit_ff))
      else $error("search scanned beyond bytes in use");
`endif

endmodule
`default_nettype wire

### dv/free_block_bitmap_tb.sv
// testbench for the free block bitmap allocator
`timescale 1ns / 100ps
module free_block_bitmap_tb;

   typedef struct packed {
      logic                         bit_value;
      logic [fbb_pkg::POS_W-1:0]    free_index;
      logic [fbb_pkg::STATUS_W-1:0] status;
   } alloc_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [fbb_pkg::KIND_W-1:0]   req_kind = fbb_pkg::KIND_MARK_USED;
   logic [fbb_pkg::POS_W-1:0]    req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_bit_value;
   logic [fbb_pkg::POS_W-1:0]    rsp_free_index;
   logic [fbb_pkg::STATUS_W-1:0] rsp_status;
   logic                         csr_wr_en = 1'b0;
   logic [fbb_pkg::CSR_W-1:0]    csr_wr_data = '0;

   logic [fbb_pkg::BLOCK_BITS-1:0] used_map [fbb_pkg::MAP_BYTES];
   logic [fbb_pkg::CSR_W-1:0]      map_bytes_cfg;
   alloc_result_type               expected_results[$];
   int                             failures = 0;
   bit                             quiet = 1'b0;

   free_block_bitmap dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bit_value  (rsp_bit_value),
      .rsp_free_index (rsp_free_index),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int active_bytes();
      return (int'(map_bytes_cfg) > fbb_pkg::MAP_BYTES) ? fbb_pkg::MAP_BYTES
                                                         : int'(map_bytes_cfg);
   endfunction

   function automatic alloc_result_type apply_request(logic [fbb_pkg::KIND_W-1:0] kind,
                                                      logic [fbb_pkg::POS_W-1:0] pos);
      alloc_result_type r;
      int               limit;
      bit               found;
      r = '0;
      limit = active_bytes();
      found = 1'b0;
      if (kind == fbb_pkg::KIND_SEARCH) begin
         for (int i = 0; i < limit && !found; i++)
            for (int j = 0; j < fbb_pkg::BLOCK_BITS && !found; j++)
               if (!used_map[i][j]) begin
                  r.free_index = fbb_pkg::POS_W'(i * fbb_pkg::BLOCK_BITS + j);
                  found = 1'b1;
               end
         if (!found) r.status = fbb_pkg::STATUS_NO_FREE;
      end else if (int'(pos) >= limit * fbb_pkg::BLOCK_BITS) begin
         r.status = fbb_pkg::STATUS_RANGE;
      end else begin
         case (kind)
            fbb_pkg::KIND_MARK_USED:
               used_map[pos / fbb_pkg::BLOCK_BITS][pos % fbb_pkg::BLOCK_BITS] = 1'b1;
            fbb_pkg::KIND_MARK_FREE:
               used_map[pos / fbb_pkg::BLOCK_BITS][pos % fbb_pkg::BLOCK_BITS] = 1'b0;
            default:
               r.bit_value = used_map[pos / fbb_pkg::BLOCK_BITS][pos % fbb_pkg::BLOCK_BITS];
         endcase
      end
      return r;
   endfunction

   function automatic logic [fbb_pkg::POS_W-1:0] pick_position();
      if (active_bytes() == 0)
         return fbb_pkg::POS_W'($urandom_range(fbb_pkg::NUM_BLOCKS - 1));
      return fbb_pkg::POS_W'($urandom_range(active_bytes() * fbb_pkg::BLOCK_BITS - 1));
   endfunction

   function automatic logic [fbb_pkg::KIND_W-1:0] random_kind();
      return fbb_pkg::KIND_W'($urandom_range(3));
   endfunction

   task automatic send_request(input logic [fbb_pkg::KIND_W-1:0] kind,
                               input logic [fbb_pkg::POS_W-1:0] pos,
                               output alloc_result_type predicted);
      while (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predicted = apply_request(kind, pos);
      expected_results.push_back(predicted);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send(input logic [fbb_pkg::KIND_W-1:0] kind,
                       input logic [fbb_pkg::POS_W-1:0] pos);
      alloc_result_type unused;
      send_request(kind, pos, unused);
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bytes_in_use(input logic [fbb_pkg::CSR_W-1:0] value);
      drain_pending();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      map_bytes_cfg = value;
      @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: free_index %0d status %0d",
                   rsp_free_index, rsp_status);
            failures++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_bit_value !== exp_r.bit_value) begin
               $error("bit_value: expected %0d, actual %0d", exp_r.bit_value, rsp_bit_value);
               failures++;
            end
            if (rsp_free_index !== exp_r.free_index) begin
               $error("free_index: expected %0d, actual %0d", exp_r.free_index,
                      rsp_free_index);
               failures++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 6);
      end
   end

   task automatic test_reset_state();
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(0));
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(fbb_pkg::NUM_BLOCKS - 1));
      send(fbb_pkg::KIND_SEARCH, '0);
   endtask

   task automatic test_mark_and_test();
      send(fbb_pkg::KIND_MARK_USED, fbb_pkg::POS_W'(fbb_pkg::NUM_BLOCKS - 1));
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(fbb_pkg::NUM_BLOCKS - 1));
      send(fbb_pkg::KIND_MARK_FREE, fbb_pkg::POS_W'(0));
      send(fbb_pkg::KIND_SEARCH, fbb_pkg::POS_W'(fbb_pkg::NUM_BLOCKS - 1));
      send(fbb_pkg::KIND_MARK_USED, fbb_pkg::POS_W'(0));
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(0));
   endtask

   task automatic test_full_map();
      write_bytes_in_use(fbb_pkg::CSR_W'(1));
      for (int b = 1; b < fbb_pkg::BLOCK_BITS; b++)
         send(fbb_pkg::KIND_MARK_USED, fbb_pkg::POS_W'(b));
      send(fbb_pkg::KIND_SEARCH, '0);
      send(fbb_pkg::KIND_MARK_USED, fbb_pkg::POS_W'(fbb_pkg::BLOCK_BITS));
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(fbb_pkg::BLOCK_BITS));
      send(fbb_pkg::KIND_MARK_FREE, fbb_pkg::POS_W'(3));
      send(fbb_pkg::KIND_SEARCH, '0);
   endtask

   task automatic test_register_extremes();
      write_bytes_in_use('0);
      send(fbb_pkg::KIND_SEARCH, '0);
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(0));
      write_bytes_in_use('1);
      send(fbb_pkg::KIND_TEST, fbb_pkg::POS_W'(fbb_pkg::NUM_BLOCKS - 1));
   endtask

   task automatic test_random_traffic(input int n_items);
      alloc_result_type found;
      int               sent;
      int               phase;
      int               pick;
      int               phase_len;
      sent = 0;
      phase = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 65)
            write_bytes_in_use(fbb_pkg::CSR_W'($urandom_range(1, 8)));
         else if (pick < 77)
            write_bytes_in_use(fbb_pkg::CSR_W'(fbb_pkg::MAP_BYTES));
         else if (pick < 90)
            write_bytes_in_use(fbb_pkg::CSR_W'($urandom_range(9, fbb_pkg::MAP_BYTES - 1)));
         else if (pick < 95)
            write_bytes_in_use('0);
         else
            write_bytes_in_use(fbb_pkg::CSR_W'($urandom_range(fbb_pkg::MAP_BYTES + 1, 255)));
         quiet = (phase == 3);
         phase_len = $urandom_range(40, 160);
         for (int k = 0; k < phase_len && sent < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
               send_request(fbb_pkg::KIND_SEARCH, fbb_pkg::POS_W'($urandom), found);
               sent++;
               if (found.status == fbb_pkg::STATUS_OK) begin
                  send(fbb_pkg::KIND_MARK_USED, found.free_index);
                  sent++;
               end
            end else begin
               if (pick < 55) send(fbb_pkg::KIND_MARK_FREE, pick_position());
               else if (pick < 70) send(fbb_pkg::KIND_TEST, pick_position());
               else if (pick < 80) send(fbb_pkg::KIND_MARK_USED, pick_position());
               else send(random_kind(), fbb_pkg::POS_W'($urandom));
               sent++;
            end
         end
         quiet = 1'b0;
         phase++;
      end
   endtask

   initial begin
      for (int i = 0; i < fbb_pkg::MAP_BYTES; i++) used_map[i] = '0;
      used_map[0][0] = 1'b1;
      map_bytes_cfg = fbb_pkg::CSR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_mark_and_test();
      test_full_map();
      test_register_extremes();
      test_random_traffic(1600);
      drain_pending();
      repeat (140) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
rtl/fbb_pkg.sv
rtl/fbb_byte_unit.sv
rtl/free_block_bitmap.sv
dv/free_block_bitmap_tb.sv
